FILE: sv/ryaw_pkg.sv
// ----------------------------------------------------------------------------
// ryaw_pkg
// shared types, constants and tables of the relative yaw core: quaternion
// record, multiply-accumulate schedule and the cordic arctangent table
// ----------------------------------------------------------------------------
package ryaw_pkg;

    localparam int Q_W     = 16;
    localparam int YAW_W   = 16;
    localparam int ANG_W   = 33;
    localparam int CNT_W   = 5;
    localparam int STEP_W  = 5;
    localparam int ATAN_LEN = 24;

    // identity real part after reset
    localparam logic signed [Q_W-1:0] REF_REAL_RESET = 16'sd16384;

    // quarter turn on the 2^31 = pi angle scale
    localparam logic signed [ANG_W-1:0] ANG_QTR = 33'sd1073741824;

    // component select codes
    localparam logic [1:0] CX = 2'd0;
    localparam logic [1:0] CY = 2'd1;
    localparam logic [1:0] CZ = 2'd2;
    localparam logic [1:0] CW = 2'd3;

    // schedule landmarks
    localparam logic [STEP_W-1:0] STEP_NUM_LAST = 5'd17;
    localparam logic [STEP_W-1:0] STEP_LAST     = 5'd21;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
        logic signed [Q_W-1:0] w;
    } ryaw_quat_t;

    typedef struct packed {
        logic first;
        logic last;
        logic sub;
        logic [1:0] a_sel;
        logic [1:0] b_sel;
    } ryaw_sched_t;

    typedef struct packed {
        logic en;
        logic first;
        logic sub;
    } ryaw_mac_ctl_t;

    // product terms of latest * conj(reference), then numerator and denominator
    function automatic ryaw_sched_t ryaw_sched(input logic [STEP_W-1:0] s);
        ryaw_sched_t r;
        case (s)
            5'd0:    r = '{1'b1, 1'b0, 1'b0, CX, CW};
            5'd1:    r = '{1'b0, 1'b0, 1'b1, CY, CZ};
            5'd2:    r = '{1'b0, 1'b0, 1'b0, CZ, CY};
            5'd3:    r = '{1'b0, 1'b1, 1'b1, CW, CX};
            5'd4:    r = '{1'b1, 1'b0, 1'b0, CX, CZ};
            5'd5:    r = '{1'b0, 1'b0, 1'b0, CY, CW};
            5'd6:    r = '{1'b0, 1'b0, 1'b1, CZ, CX};
            5'd7:    r = '{1'b0, 1'b1, 1'b1, CW, CY};
            5'd8:    r = '{1'b1, 1'b0, 1'b1, CX, CY};
            5'd9:    r = '{1'b0, 1'b0, 1'b0, CY, CX};
            5'd10:   r = '{1'b0, 1'b0, 1'b0, CZ, CW};
            5'd11:   r = '{1'b0, 1'b1, 1'b1, CW, CZ};
            5'd12:   r = '{1'b1, 1'b0, 1'b0, CW, CW};
            5'd13:   r = '{1'b0, 1'b0, 1'b0, CX, CX};
            5'd14:   r = '{1'b0, 1'b0, 1'b0, CY, CY};
            5'd15:   r = '{1'b0, 1'b1, 1'b0, CZ, CZ};
            5'd16:   r = '{1'b1, 1'b0, 1'b0, CW, CZ};
            5'd17:   r = '{1'b0, 1'b1, 1'b0, CX, CY};
            5'd18:   r = '{1'b1, 1'b0, 1'b0, CW, CW};
            5'd19:   r = '{1'b0, 1'b0, 1'b0, CX, CX};
            5'd20:   r = '{1'b0, 1'b0, 1'b1, CY, CY};
            5'd21:   r = '{1'b0, 1'b1, 1'b1, CZ, CZ};
            default: r = '0;
        endcase
        return r;
    endfunction

    // atan(2^-i) on the 2^31 = pi scale
    function automatic logic [31:0] ryaw_atan(input logic [CNT_W-1:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:    v = 32'd536870912;
            5'd1:    v = 32'd316933406;
            5'd2:    v = 32'd167458907;
            5'd3:    v = 32'd85004756;
            5'd4:    v = 32'd42667331;
            5'd5:    v = 32'd21354465;
            5'd6:    v = 32'd10679838;
            5'd7:    v = 32'd5340245;
            5'd8:    v = 32'd2670163;
            5'd9:    v = 32'd1335087;
            5'd10:   v = 32'd667544;
            5'd11:   v = 32'd333772;
            5'd12:   v = 32'd166886;
            5'd13:   v = 32'd83443;
            5'd14:   v = 32'd41722;
            5'd15:   v = 32'd20861;
            5'd16:   v = 32'd10430;
            5'd17:   v = 32'd5215;
            5'd18:   v = 32'd2608;
            5'd19:   v = 32'd1304;
            5'd20:   v = 32'd652;
            5'd21:   v = 32'd326;
            5'd22:   v = 32'd163;
            5'd23:   v = 32'd81;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

FILE: sv/relative_yaw_from_quaternion_core.sv
// ----------------------------------------------------------------------------
// relative_yaw_from_quaternion_core
// yaw of the latest orientation quaternion relative to a captured reference
// ----------------------------------------------------------------------------
// Each input beat is a quaternion sample (kind 0) or a re-zero request
// (kind 1); every beat gives one output beat with the relative yaw as a
// binary angle (32768 = pi), the ready flag and whether a new reference was
// captured. The first sample becomes the reference. An item occupies the
// block from accept to output: the quaternion product and the atan2 operands
// on the single multiply-accumulate unit, then the CORDIC iterations, then
// the hand-over, which waits while a full output register is stalled.
// in_stall is high for that whole time; a finished beat waits in the output
// register without holding off the next input.
module relative_yaw_from_quaternion_core #(
    parameter int CORDIC_STEPS   = 16,
    parameter int QUAT_FRAC_BITS = 14
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic                            kind,
    input  logic signed [ryaw_pkg::Q_W-1:0] quat_i,
    input  logic signed [ryaw_pkg::Q_W-1:0] quat_j,
    input  logic signed [ryaw_pkg::Q_W-1:0] quat_k,
    input  logic signed [ryaw_pkg::Q_W-1:0] quat_real,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic signed [ryaw_pkg::YAW_W-1:0] yaw_angle,
    output logic                            is_ready,
    output logic                            reset_done
);
    import ryaw_pkg::*;

    localparam int P_W   = 34 - QUAT_FRAC_BITS;
    localparam int M_W   = (P_W > Q_W) ? P_W : Q_W;
    localparam int D_W   = 69 - 2 * QUAT_FRAC_BITS;
    localparam int A_W   = (D_W > 34) ? D_W : 34;
    localparam int C_W   = D_W + 2;
    localparam int STEPS = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MAC   = 3'd1;
    localparam logic [2:0] S_START = 3'd2;
    localparam logic [2:0] S_CORD  = 3'd3;
    localparam logic [2:0] S_PUT   = 3'd4;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [STEP_W-1:0]       step_reg;
    ryaw_quat_t              lat_reg;
    ryaw_quat_t              ref_reg;
    logic                    ready_reg;
    logic                    rdone_reg;
    logic signed [P_W-1:0]   px_reg;
    logic signed [P_W-1:0]   py_reg;
    logic signed [P_W-1:0]   pz_reg;
    logic signed [P_W-1:0]   pw_reg;
    logic signed [D_W-1:0]   num_reg;
    logic signed [D_W-1:0]   den_reg;
    logic                    out_valid_reg;
    logic signed [YAW_W-1:0] yaw_reg;
    logic                    ready_out_reg;
    logic                    rdone_out_reg;

    ryaw_sched_t             sched;
    ryaw_mac_ctl_t           mac_ctl;
    logic signed [M_W-1:0]   a_op;
    logic signed [M_W-1:0]   b_op;
    logic signed [A_W-1:0]   mac_sum;
    logic                    cord_start;
    logic                    cord_done;
    logic signed [YAW_W-1:0] cord_angle;
    logic                    in_fire;
    logic                    out_fire;
    logic                    put_ok;

    assign in_stall = (state_reg != S_IDLE);
    assign in_fire  = in_valid && !in_stall;
    assign out_fire = out_valid_reg && !out_stall;
    assign put_ok   = !out_valid_reg || !out_stall;

    assign sched         = ryaw_sched(step_reg);
    assign mac_ctl.en    = (state_reg == S_MAC);
    assign mac_ctl.first = sched.first;
    assign mac_ctl.sub   = sched.sub;
    assign cord_start    = (state_reg == S_START);

    // operands: latest and reference during the product, p components after
    always_comb
    begin
        if (step_reg[STEP_W-1])
        begin
            case (sched.a_sel)
                CX:      a_op = M_W'(px_reg);
                CY:      a_op = M_W'(py_reg);
                CZ:      a_op = M_W'(pz_reg);
                default: a_op = M_W'(pw_reg);
            endcase
            case (sched.b_sel)
                CX:      b_op = M_W'(px_reg);
                CY:      b_op = M_W'(py_reg);
                CZ:      b_op = M_W'(pz_reg);
                default: b_op = M_W'(pw_reg);
            endcase
        end
        else
        begin
            case (sched.a_sel)
                CX:      a_op = M_W'(lat_reg.x);
                CY:      a_op = M_W'(lat_reg.y);
                CZ:      a_op = M_W'(lat_reg.z);
                default: a_op = M_W'(lat_reg.w);
            endcase
            case (sched.b_sel)
                CX:      b_op = M_W'(ref_reg.x);
                CY:      b_op = M_W'(ref_reg.y);
                CZ:      b_op = M_W'(ref_reg.z);
                default: b_op = M_W'(ref_reg.w);
            endcase
        end
    end

    ryaw_mac #(
        .M_W (M_W),
        .A_W (A_W)
    ) u_mac (
        .clk (clk),
        .ctl (mac_ctl),
        .a   (a_op),
        .b   (b_op),
        .sum (mac_sum)
    );

    ryaw_cordic #(
        .D_W   (D_W),
        .C_W   (C_W),
        .STEPS (STEPS)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cord_start),
        .x_in  (den_reg),
        .y_in  (num_reg),
        .done  (cord_done),
        .angle (cord_angle)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                if (step_reg == STEP_LAST)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                state_next = S_CORD;
            end
            S_CORD:
            begin
                if (cord_done)
                begin
                    state_next = S_PUT;
                end
            end
            S_PUT:
            begin
                if (put_ok)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            lat_reg       <= '0;
            ref_reg       <= '{x: '0, y: '0, z: '0, w: REF_REAL_RESET};
            ready_reg     <= 1'b0;
            rdone_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_fire)
            begin
                step_reg <= '0;
                if (!kind)
                begin
                    lat_reg   <= '{x: quat_i, y: quat_j, z: quat_k, w: quat_real};
                    rdone_reg <= 1'b0;
                    if (!ready_reg)
                    begin
                        ready_reg <= 1'b1;
                        ref_reg   <= '{x: quat_i, y: quat_j, z: quat_k, w: quat_real};
                    end
                end
                else
                begin
                    // re-zero only once a sample has arrived
                    rdone_reg <= ready_reg;
                    if (ready_reg)
                    begin
                        ref_reg <= lat_reg;
                    end
                end
            end
            else if (state_reg == S_MAC)
            begin
                step_reg <= step_reg + 1'b1;
            end

            if ((state_reg == S_PUT) && put_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_fire)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_MAC) && sched.last)
        begin
            if (!step_reg[STEP_W-1])
            begin
                case (step_reg[3:2])
                    CX:      px_reg <= signed'(mac_sum[QUAT_FRAC_BITS +: P_W]);
                    CY:      py_reg <= signed'(mac_sum[QUAT_FRAC_BITS +: P_W]);
                    CZ:      pz_reg <= signed'(mac_sum[QUAT_FRAC_BITS +: P_W]);
                    default: pw_reg <= signed'(mac_sum[QUAT_FRAC_BITS +: P_W]);
                endcase
            end
            else if (step_reg == STEP_NUM_LAST)
            begin
                num_reg <= signed'({mac_sum[D_W-2:0], 1'b0});
            end
            else
            begin
                den_reg <= signed'(mac_sum[D_W-1:0]);
            end
        end

        if ((state_reg == S_PUT) && put_ok)
        begin
            yaw_reg       <= cord_angle;
            ready_out_reg <= ready_reg;
            rdone_out_reg <= rdone_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign yaw_angle  = yaw_reg;
    assign is_ready   = ready_out_reg;
    assign reset_done = rdone_out_reg;

    a_accept_starts_mac: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg == S_MAC && step_reg == '0))
        else $error("accepted beat did not start the product sequence");

    a_done_in_cordic: assert property (@(posedge clk) disable iff (!rst_n)
        cord_done |-> (state_reg == S_CORD))
        else $error("cordic finished outside its phase");

    a_out_from_put: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == S_PUT))
        else $error("output beat raised without a finished item");

    a_capture_needs_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rdone_out_reg) |-> ready_out_reg)
        else $error("reference captured while not ready");

    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        ready_reg |=> ready_reg)
        else $error("ready flag dropped");

endmodule

FILE: sv/ryaw_mac.sv
// ----------------------------------------------------------------------------
// ryaw_mac
// shared signed multiply-accumulate unit, one product per cycle while enabled
// ----------------------------------------------------------------------------
module ryaw_mac #(
    parameter int M_W = 20,
    parameter int A_W = 41
) (
    input  logic                      clk,
    input  ryaw_pkg::ryaw_mac_ctl_t   ctl,
    input  logic signed [M_W-1:0]     a,
    input  logic signed [M_W-1:0]     b,
    output logic signed [A_W-1:0]     sum
);
    import ryaw_pkg::*;

    logic signed [2*M_W-1:0] prod;
    logic signed [A_W-1:0]   prod_ext;
    logic signed [A_W-1:0]   base;
    logic signed [A_W-1:0]   acc_reg;
    logic signed [A_W-1:0]   acc_next;

    assign prod     = a * b;
    assign prod_ext = A_W'(prod);
    assign base     = ctl.first ? '0 : acc_reg;
    assign acc_next = ctl.sub ? (base - prod_ext) : (base + prod_ext);
    assign sum      = acc_next;

    always_ff @(posedge clk)
    begin
        if (ctl.en)
        begin
            acc_reg <= acc_next;
        end
    end

endmodule

FILE: sv/ryaw_cordic.sv
// ----------------------------------------------------------------------------
// ryaw_cordic
// iterative vectoring cordic, one rotation step per cycle, binary angle out
// ----------------------------------------------------------------------------
module ryaw_cordic #(
    parameter int D_W   = 41,
    parameter int C_W   = 43,
    parameter int STEPS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [D_W-1:0] x_in,
    input  logic signed [D_W-1:0] y_in,
    output logic                  done,
    output logic signed [ryaw_pkg::YAW_W-1:0] angle
);
    import ryaw_pkg::*;

    logic                    run_reg;
    logic                    done_reg;
    logic                    zero_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic signed [C_W-1:0]   x_reg;
    logic signed [C_W-1:0]   y_reg;
    logic signed [ANG_W-1:0] acc_reg;
    logic signed [YAW_W-1:0] angle_reg;

    logic signed [C_W-1:0]   xe;
    logic signed [C_W-1:0]   ye;
    logic signed [C_W-1:0]   dx;
    logic signed [C_W-1:0]   dy;
    logic signed [C_W-1:0]   x_next;
    logic signed [C_W-1:0]   y_next;
    logic signed [ANG_W-1:0] step_ang;
    logic signed [ANG_W-1:0] acc_next;
    logic signed [ANG_W-1:0] rnd;
    logic                    last;

    assign xe       = C_W'(x_in);
    assign ye       = C_W'(y_in);
    assign dx       = y_reg >>> cnt_reg;
    assign dy       = x_reg >>> cnt_reg;
    assign step_ang = signed'({1'b0, ryaw_atan(cnt_reg)});
    assign last     = (cnt_reg == CNT_W'(STEPS - 1));

    always_comb
    begin
        if (y_reg > 0)
        begin
            x_next   = x_reg + dx;
            y_next   = y_reg - dy;
            acc_next = acc_reg + step_ang;
        end
        else
        begin
            x_next   = x_reg - dx;
            y_next   = y_reg + dy;
            acc_next = acc_reg - step_ang;
        end
    end

    // round half up to 16 bits, wraps a half turn to the negative end
    assign rnd = acc_next + 33'sd32768;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            zero_reg <= (x_in == '0) && (y_in == '0);
            // fold the left half plane by a quarter turn
            if (xe < 0)
            begin
                if (ye >= 0)
                begin
                    x_reg   <= ye;
                    y_reg   <= -xe;
                    acc_reg <= ANG_QTR;
                end
                else
                begin
                    x_reg   <= -ye;
                    y_reg   <= xe;
                    acc_reg <= -ANG_QTR;
                end
            end
            else
            begin
                x_reg   <= xe;
                y_reg   <= ye;
                acc_reg <= '0;
            end
        end
        else if (run_reg)
        begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
            if (last)
            begin
                angle_reg <= zero_reg ? '0 : rnd[31:16];
            end
        end
    end

    assign done  = done_reg;
    assign angle = angle_reg;

endmodule

FILE: tb/relative_yaw_from_quaternion_core_tb.sv
// ----------------------------------------------------------------------------
// relative_yaw_from_quaternion_core_tb
// self-checking bench for the relative yaw core
// ----------------------------------------------------------------------------
// Drives quaternion samples and re-zero requests through the input channel.
// A bit-accurate predictor tracks the latest sample, the reference and the
// ready flag, and works out the product with the conjugate reference and the
// cordic atan2 for every accepted beat. Each output beat is checked field by
// field against the oldest prediction. A directed part covers re-zero before
// the first sample, the first sample, half and quarter turns, the zero vector
// and extreme component patterns. Random phases follow, with no idling, with
// sender gaps, with receiver stalls and with both, and one full drain pause.
// ----------------------------------------------------------------------------
module relative_yaw_from_quaternion_core_tb;

    import ryaw_pkg::*;

    localparam int CORDIC_STEPS   = 16;
    localparam int QUAT_FRAC_BITS = 14;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_REZERO = 1'b1;

    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     TAIL_CYCLES    = 80;
    localparam int     PRINT_LIMIT    = 40;
    localparam longint QUARTER_TURN   = 64'sd1073741824;

    // atan(2^-i), 2^31 = pi
    localparam longint ATAN_STEP [24] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81
    };

    typedef struct {
        logic signed [YAW_W-1:0] yaw;
        logic                    ready;
        logic                    captured;
    } yaw_result_t;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    kind      = 1'b0;
    logic signed [Q_W-1:0]   quat_i    = '0;
    logic signed [Q_W-1:0]   quat_j    = '0;
    logic signed [Q_W-1:0]   quat_k    = '0;
    logic signed [Q_W-1:0]   quat_real = '0;
    logic                    out_stall = 1'b0;
    logic                    in_stall;
    logic                    out_valid;
    logic signed [YAW_W-1:0] yaw_angle;
    logic                    is_ready;
    logic                    reset_done;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int result_count   = 0;
    int quiet_cycles   = 0;

    // predictor state
    ryaw_quat_t  latest_pose = '0;
    ryaw_quat_t  zero_pose   = '{x: '0, y: '0, z: '0, w: REF_REAL_RESET};
    logic        have_sample = 1'b0;
    yaw_result_t yaw_expected [$];
    yaw_result_t oldest_yaw;

    // last sample driven by the random generator, for small perturbations
    logic [Q_W-1:0] prev_comp [4] = '{16'h0000, 16'h0000, 16'h0000, 16'h4000};

    relative_yaw_from_quaternion_core #(
        .CORDIC_STEPS  (CORDIC_STEPS),
        .QUAT_FRAC_BITS(QUAT_FRAC_BITS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .quat_i    (quat_i),
        .quat_j    (quat_j),
        .quat_k    (quat_k),
        .quat_real (quat_real),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .yaw_angle (yaw_angle),
        .is_ready  (is_ready),
        .reset_done(reset_done)
    );

    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // vectoring cordic, angle on the 2^31 = pi scale, rounded to 16 bits
    function automatic longint cordic_yaw(input longint y_in, input longint x_in);
        longint xv;
        longint yv;
        longint acc;
        longint t;
        longint dx;
        longint dy;
        int     n_steps;
        xv = x_in;
        yv = y_in;
        acc = 0;
        n_steps = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        if (xv == 0 && yv == 0)
            return 0;
        // fold the left half plane onto the right one
        if (xv < 0)
        begin
            t = xv;
            if (yv >= 0)
            begin
                xv = yv;
                yv = -t;
                acc = QUARTER_TURN;
            end
            else
            begin
                xv = -yv;
                yv = t;
                acc = -QUARTER_TURN;
            end
        end
        for (int i = 0; i < n_steps; i++)
        begin
            dx = yv >>> i;
            dy = xv >>> i;
            if (yv > 0)
            begin
                xv += dx;
                yv -= dy;
                acc += ATAN_STEP[i];
            end
            else
            begin
                xv -= dx;
                yv += dy;
                acc -= ATAN_STEP[i];
            end
        end
        return (acc + 32768) >>> 16;
    endfunction

    // yaw of a * conj(r)
    function automatic logic signed [YAW_W-1:0] relative_yaw_of(input ryaw_quat_t a,
                                                                input ryaw_quat_t r);
        longint ax, ay, az, aw;
        longint bx, by, bz, bw;
        longint px, py, pz, pw;
        longint num, den, ang;
        ax = a.x;
        ay = a.y;
        az = a.z;
        aw = a.w;
        bx = -longint'(r.x);
        by = -longint'(r.y);
        bz = -longint'(r.z);
        bw = r.w;
        px = (ax * bw + ay * bz - az * by + aw * bx) >>> QUAT_FRAC_BITS;
        py = (-ax * bz + ay * bw + az * bx + aw * by) >>> QUAT_FRAC_BITS;
        pz = (ax * by - ay * bx + az * bw + aw * bz) >>> QUAT_FRAC_BITS;
        pw = (aw * bw - ax * bx - ay * by - az * bz) >>> QUAT_FRAC_BITS;
        num = 2 * (pw * pz + px * py);
        den = pw * pw + px * px - py * py - pz * pz;
        ang = cordic_yaw(num, den);
        return ang[YAW_W-1:0];
    endfunction

    task automatic predict_yaw(input logic k, input ryaw_quat_t s);
        yaw_result_t e;
        e.captured = 1'b0;
        if (k == KIND_SAMPLE)
        begin
            latest_pose = s;
            if (!have_sample)
            begin
                have_sample = 1'b1;
                zero_pose = s;
            end
        end
        else if (have_sample)
        begin
            zero_pose = latest_pose;
            e.captured = 1'b1;
        end
        e.yaw = relative_yaw_of(latest_pose, zero_pose);
        e.ready = have_sample;
        yaw_expected.push_back(e);
    endtask

    task automatic report_mismatch(input string msg);
        if (error_count < PRINT_LIMIT)
            $display("mismatch at result %0d: %s", result_count, msg);
        error_count++;
    endtask

    // input and output monitors share one block: predict first, then check
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                predict_yaw(kind, '{x: quat_i, y: quat_j, z: quat_k, w: quat_real});
            if (out_valid && !out_stall)
            begin
                if (yaw_expected.size() == 0)
                    report_mismatch("output beat with nothing expected");
                else
                begin
                    oldest_yaw = yaw_expected.pop_front();
                    if (yaw_angle !== oldest_yaw.yaw)
                        report_mismatch($sformatf("yaw_angle got %0d want %0d",
                                                  yaw_angle, oldest_yaw.yaw));
                    if (is_ready !== oldest_yaw.ready)
                        report_mismatch($sformatf("is_ready got %b want %b",
                                                  is_ready, oldest_yaw.ready));
                    if (reset_done !== oldest_yaw.captured)
                        report_mismatch($sformatf("reset_done got %b want %b",
                                                  reset_done, oldest_yaw.captured));
                end
                result_count++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved in %0d cycles", WATCHDOG_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    // one input beat; returns in the step of the accepting edge
    task automatic send_beat(input logic k, input logic [Q_W-1:0] qi, input logic [Q_W-1:0] qj,
                             input logic [Q_W-1:0] qk, input logic [Q_W-1:0] qr);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        kind      <= k;
        quat_i    <= qi;
        quat_j    <= qj;
        quat_k    <= qk;
        quat_real <= qr;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // sender holds off until every predicted beat has come out
    task automatic wait_results_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (yaw_expected.size() != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic test_directed();
        send_idle_pct = 0;
        // re-zero before any sample: quat fields are don't-care
        send_beat(KIND_REZERO, 16'h7fff, 16'h8000, 16'h1234, 16'hffff);
        send_beat(KIND_REZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // first sample becomes the reference
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h4000);
        // half turn about z, both signs
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h4000, 16'h0000);
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'hc000, 16'h0000);
        // quarter turns about z, then half turns about x and y
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h2d41, 16'h2d41);
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'hd2bf, 16'h2d41);
        send_beat(KIND_SAMPLE, 16'h4000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(KIND_SAMPLE, 16'h0000, 16'h4000, 16'h0000, 16'h0000);
        // zero latest, then capture it as the reference
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_beat(KIND_REZERO, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
        send_beat(KIND_SAMPLE, 16'h4000, 16'h4000, 16'h4000, 16'h4000);
        send_beat(KIND_REZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        // extreme component patterns
        send_beat(KIND_SAMPLE, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
        send_beat(KIND_SAMPLE, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
        send_beat(KIND_SAMPLE, 16'hc000, 16'hc000, 16'hc000, 16'hc000);
        send_beat(KIND_SAMPLE, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
        send_beat(KIND_SAMPLE, 16'h7fff, 16'h8000, 16'h4000, 16'hc000);
        send_beat(KIND_REZERO, 16'h5555, 16'haaaa, 16'h5555, 16'haaaa);
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'h0001, 16'h4000);
        send_beat(KIND_SAMPLE, 16'h0000, 16'h0000, 16'hffff, 16'hc000);
        send_beat(KIND_REZERO, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    task automatic send_random_beat();
        int             pick;
        int             mode;
        int             v;
        logic [Q_W-1:0] q [4];
        pick = $urandom_range(99);
        mode = $urandom_range(99);
        for (int n = 0; n < 4; n++)
        begin
            if (mode < 40)
                v = int'($urandom_range(32768)) - 16384;
            else if (mode < 60)
                v = $urandom();
            else if (mode < 90)
                v = int'($signed(prev_comp[n])) + int'($urandom_range(512)) - 256;
            else
            begin
                case ($urandom_range(4))
                    0:       v = -32768;
                    1:       v = -16384;
                    2:       v = 0;
                    3:       v = 16384;
                    default: v = 32767;
                endcase
            end
            q[n] = v[Q_W-1:0];
        end
        if (pick < 15)
            send_beat(KIND_REZERO, q[0], q[1], q[2], q[3]);
        else
        begin
            prev_comp = q;
            send_beat(KIND_SAMPLE, q[0], q[1], q[2], q[3]);
        end
    endtask

    task automatic test_random_phase(input int n_items, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int n = 0; n < n_items; n++)
            send_random_beat();
    endtask

    task automatic test_drain_pause();
        send_idle_pct = 0;
        recv_stall_pct = 27;
        for (int n = 0; n < 10; n++)
            send_random_beat();
        wait_results_drained();
        for (int n = 0; n < 10; n++)
            send_random_beat();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_random_phase(170, 0, 0);
        test_drain_pause();
        test_random_phase(170, 62, 0);
        test_random_phase(170, 0, 62);
        test_random_phase(170, 27, 27);

        wait_results_drained();
        recv_stall_pct = 0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (yaw_expected.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", yaw_expected.size()));
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

FILE: files.f
sv/ryaw_pkg.sv
sv/ryaw_mac.sv
sv/ryaw_cordic.sv
sv/relative_yaw_from_quaternion_core.sv
tb/relative_yaw_from_quaternion_core_tb.sv
